@@ hdl/sha1sb_pkg.sv @@
// shared types, constants and helper functions for the single-block sha-1 hasher
// used by every module of the block except sha1sb_ram, depends on nothing

package sha1sb_pkg;

  // message buffer geometry
  localparam int BUF_BYTES  = 55;
  localparam int WORD_BITS  = 32;
  localparam int SLOT_BITS  = 4;                  // 16 word slots per bank
  localparam int RAM_AW     = SLOT_BITS + 1;      // bank bit on top
  localparam int RAM_DEPTH  = 1 << RAM_AW;
  localparam int LEN_BITS   = 6;
  localparam int NUM_ROUNDS = 80;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_LONG = 1'b1;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ROUND,
    BK_EMIT
  } back_state_t;

  // one finished message waiting for the hash engine
  typedef struct packed {
    logic                bank;
    logic [LEN_BITS-1:0] len;
    logic                ovf;
  } job_t;

  typedef struct packed {
    logic                 en;
    logic [RAM_AW-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } ram_wr_t;

  function automatic logic [31:0] init_val(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_func(input logic [6:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

@@ hdl/sha1_single_block_hash.sv @@
// top level of the single-block sha-1 hasher
// instantiates sha1sb_front, sha1sb_ram, sha1sb_queue and sha1sb_back; uses sha1sb_pkg
//
// usage:
//  - input channel: one message byte per item on in_data_byte, taken at a rising edge
//    with start high and busy low; in_last_byte high marks the final byte of a message
//  - a message of 1 to 55 bytes yields five result items, digest words 0 to 4, most
//    significant first, on consecutive cycles, final_word high on the fifth
//  - a longer message yields one result item: digest word 0, index 0, final_word and
//    status high; bytes past the 55th are dropped
//  - each result is shown for exactly one cycle with out_strobe high; the receiver
//    cannot stall, so no backpressure exists on the result side
// timing:
//  - the front end takes one byte per cycle unless busy; bytes go into one of two ram banks
//  - a finished message waits in a two-entry queue for the hash engine, which picks it
//    up, loads the block through the registered ram read, runs the 80 rounds and emits
//    the five words; an error result skips the load and the rounds and is emitted
//    straight from the idle state when the engine is free
//  - while the engine works the front end keeps taking the next message; busy is high
//    only when both banks hold messages not yet loaded by the engine
// reset: rst_n low clears the byte count, queue and engine state; no clearing pass

module sha1_single_block_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_strobe,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word,
  output logic        out_status
);

  sha1sb_pkg::ram_wr_t                ram_wr;
  sha1sb_pkg::job_t                   push_job;
  sha1sb_pkg::job_t                   head_job;
  logic                               push;
  logic                               pop;
  logic                               q_valid;
  logic                               q_full;
  logic [sha1sb_pkg::RAM_AW-1:0]      raddr;
  logic [sha1sb_pkg::WORD_BITS-1:0]   rdata;

  // busy only when no bank is free for a new message
  assign busy = q_full;

  sha1sb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .q_full    (q_full),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .ram_wr    (ram_wr),
    .push      (push),
    .job       (push_job)
  );

  // message buffer: two banks of sixteen 32-bit word slots
  sha1sb_ram #(
    .WIDTH (sha1sb_pkg::WORD_BITS),
    .DEPTH (sha1sb_pkg::RAM_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  sha1sb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (head_job)
  );

  sha1sb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_valid),
    .job         (head_job),
    .pop         (pop),
    .raddr       (raddr),
    .rdata       (rdata),
    .strobe      (out_strobe),
    .digest_word (out_digest_word),
    .word_index  (out_word_index),
    .final_word  (out_final_word),
    .status      (out_status)
  );

endmodule

@@ hdl/sha1sb_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// standalone, no package dependency

module sha1sb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sha1sb_front.sv @@
// front end: takes message bytes, packs them big-endian into words in the buffer ram
// and hands each finished message to the job queue; depends on sha1sb_pkg

module sha1sb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 q_full,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output sha1sb_pkg::ram_wr_t  ram_wr,
  output logic                 push,
  output sha1sb_pkg::job_t     job
);

  logic [sha1sb_pkg::LEN_BITS-1:0]  cnt_r, cnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             bank_r, bank_nxt;
  logic [sha1sb_pkg::WORD_BITS-1:0] word_r, word_nxt;

  logic        accept;
  logic        stored;
  logic [1:0]  lane;
  logic [31:0] base;
  logic [31:0] ins;
  logic [31:0] pad;

  assign accept = start & ~q_full;
  assign stored = (cnt_r != sha1sb_pkg::LEN_BITS'(sha1sb_pkg::BUF_BYTES));
  assign lane   = cnt_r[1:0];
  assign base   = (lane == 2'd0) ? 32'h0 : word_r;

  always_comb begin
    case (lane)
      2'd0:    ins = {data_byte, 24'h0};
      2'd1:    ins = {base[31:24], data_byte, 16'h0};
      2'd2:    ins = {base[31:16], data_byte, 8'h0};
      default: ins = {base[31:8], data_byte};
    endcase
    // pad marker goes into the lane after the last byte, if that lane is in this word
    case (lane)
      2'd0:    pad = {8'h0, sha1sb_pkg::PAD_BYTE, 16'h0};
      2'd1:    pad = {16'h0, sha1sb_pkg::PAD_BYTE, 8'h0};
      2'd2:    pad = {24'h0, sha1sb_pkg::PAD_BYTE};
      default: pad = 32'h0;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    bank_nxt    = bank_r;
    word_nxt    = word_r;
    ram_wr.en   = 1'b0;
    ram_wr.addr = {bank_r, cnt_r[5:2]};
    ram_wr.data = last_byte ? (ins | pad) : ins;
    push        = 1'b0;
    job.bank    = bank_r;
    job.len     = stored ? (cnt_r + 1'b1) : cnt_r;
    job.ovf     = ovf_r | ~stored;
    if (accept) begin
      if (stored) begin
        word_nxt  = ins;
        cnt_nxt   = cnt_r + 1'b1;
        ram_wr.en = (lane == 2'd3) | last_byte;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (last_byte) begin
        push     = 1'b1;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

@@ hdl/sha1sb_queue.sv @@
// two-entry job queue between front end and hash engine, one entry per buffer bank
// depends on sha1sb_pkg

module sha1sb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sha1sb_pkg::job_t push_job,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output sha1sb_pkg::job_t head
);

  sha1sb_pkg::job_t q_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

endmodule

@@ hdl/sha1sb_back.sv @@
// hash engine: loads the padded block from the buffer ram, runs 80 sha-1 rounds
// and emits the five digest words or one error result; depends on sha1sb_pkg

module sha1sb_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  input  sha1sb_pkg::job_t                 job,
  output logic                             pop,
  output logic [sha1sb_pkg::RAM_AW-1:0]    raddr,
  input  logic [sha1sb_pkg::WORD_BITS-1:0] rdata,
  output logic                             strobe,
  output logic [31:0]                      digest_word,
  output logic [2:0]                       word_index,
  output logic                             final_word,
  output logic                             status
);

  sha1sb_pkg::back_state_t state_r, state_nxt;

  logic [4:0]  ld_cnt_r, ld_cnt_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic        vld_r, vld_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;
  logic        stat_r, stat_nxt;

  logic [3:0]  ld_slot;
  logic [6:0]  nwords;
  logic [31:0] ld_word;
  logic [31:0] sched_x;
  logic [31:0] sched_new;
  logic [31:0] tmp;
  logic [31:0] var_sel;

  assign raddr   = {job.bank, ld_cnt_r[3:0]};
  assign ld_slot = 4'(ld_cnt_r - 5'd1);
  assign nwords  = ({1'b0, job.len} + 7'd3) >> 2;

  // padded block word: message, marker word if len%4 == 0, zeros, bit length last
  always_comb begin
    if ({3'b0, ld_slot} < nwords) begin
      ld_word = rdata;
    end else if (({3'b0, ld_slot} == nwords) && (job.len[1:0] == 2'd0)) begin
      ld_word = {sha1sb_pkg::PAD_BYTE, 24'h0};
    end else if (ld_slot == 4'd15) begin
      ld_word = {23'h0, job.len, 3'b000};
    end else begin
      ld_word = 32'h0;
    end
  end

  assign sched_x   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign tmp = {a_r[26:0], a_r[31:27]} + sha1sb_pkg::round_func(rnd_r, b_r, c_r, d_r)
               + e_r + w_r[0] + sha1sb_pkg::round_const(rnd_r);

  always_comb begin
    case (idx_r)
      3'd0:    var_sel = a_r;
      3'd1:    var_sel = b_r;
      3'd2:    var_sel = c_r;
      3'd3:    var_sel = d_r;
      default: var_sel = e_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ld_cnt_nxt = ld_cnt_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    e_nxt      = e_r;
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    vld_nxt  = 1'b0;
    word_nxt = word_r;
    oidx_nxt = oidx_r;
    fin_nxt  = fin_r;
    stat_nxt = stat_r;
    pop      = 1'b0;
    case (state_r)
      sha1sb_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (job.ovf) begin
            vld_nxt  = 1'b1;
            word_nxt = 32'h0;
            oidx_nxt = 3'd0;
            fin_nxt  = 1'b1;
            stat_nxt = sha1sb_pkg::STATUS_LONG;
            pop      = 1'b1;
          end else begin
            ld_cnt_nxt = '0;
            state_nxt  = sha1sb_pkg::BK_LOAD;
          end
        end
      end
      sha1sb_pkg::BK_LOAD: begin
        if (ld_cnt_r != 5'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = ld_word;
        end
        if (ld_cnt_r == 5'd16) begin
          pop       = 1'b1;
          rnd_nxt   = '0;
          a_nxt     = sha1sb_pkg::init_val(3'd0);
          b_nxt     = sha1sb_pkg::init_val(3'd1);
          c_nxt     = sha1sb_pkg::init_val(3'd2);
          d_nxt     = sha1sb_pkg::init_val(3'd3);
          e_nxt     = sha1sb_pkg::init_val(3'd4);
          state_nxt = sha1sb_pkg::BK_ROUND;
        end else begin
          ld_cnt_nxt = ld_cnt_r + 5'd1;
        end
      end
      sha1sb_pkg::BK_ROUND: begin
        a_nxt = tmp;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = sched_new;
        if (rnd_r == 7'(sha1sb_pkg::NUM_ROUNDS - 1)) begin
          idx_nxt   = '0;
          state_nxt = sha1sb_pkg::BK_EMIT;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      sha1sb_pkg::BK_EMIT: begin
        vld_nxt  = 1'b1;
        word_nxt = sha1sb_pkg::init_val(idx_r) + var_sel;
        oidx_nxt = idx_r;
        fin_nxt  = (idx_r == sha1sb_pkg::LAST_WORD_IDX);
        stat_nxt = sha1sb_pkg::STATUS_OK;
        if (idx_r == sha1sb_pkg::LAST_WORD_IDX) begin
          state_nxt = sha1sb_pkg::BK_IDLE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      default: begin
        state_nxt = sha1sb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1sb_pkg::BK_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    ld_cnt_r <= ld_cnt_nxt;
    rnd_r    <= rnd_nxt;
    idx_r    <= idx_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    e_r      <= e_nxt;
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
    word_r <= word_nxt;
    oidx_r <= oidx_nxt;
    fin_r  <= fin_nxt;
    stat_r <= stat_nxt;
  end

  assign strobe      = vld_r;
  assign digest_word = word_r;
  assign word_index  = oidx_r;
  assign final_word  = fin_r;
  assign status      = stat_r;

endmodule

@@ test/sha1_digest_checker.sv @@
// digest checker for sha1_single_block_hash: tracks accepted message bytes, predicts the
// sha-1 digest words of each message and compares them with the result channel
// depends on sha1sb_pkg for the buffer size, pad byte and status codes

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_strobe,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_final_word,
  input  logic        out_status,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked
);

  localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_w;
    logic        status;
  } digest_item_t;

  digest_item_t expected_words[$];

  logic [7:0]  msg_bytes [sha1sb_pkg::BUF_BYTES];
  int unsigned buffered_bytes;
  logic        overran;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] iv_word(input int unsigned i);
    return SHA1_IV[159 - 32 * i -: 32];
  endfunction

  function automatic logic [31:0] mix_const(input int unsigned t);
    logic [31:0] k;
    case (t / 20)
      0:       k = 32'h5A827999;
      1:       k = 32'h6ED9EBA1;
      2:       k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  // pad one block, run 80 rounds, queue the five digest words
  task automatic predict_digest();
    logic [7:0]   blk [64];
    logic [31:0]  sched [80];
    logic [31:0]  a, b, c, d, e, f, tmp;
    logic [15:0]  nbits;
    digest_item_t item;
    int unsigned  t;
    for (t = 0; t < 64; t++) blk[t] = 8'h00;
    for (t = 0; t < buffered_bytes; t++) blk[t] = msg_bytes[t];
    blk[buffered_bytes] = sha1sb_pkg::PAD_BYTE;
    nbits = 16'(buffered_bytes * 8);
    blk[62] = nbits[15:8];
    blk[63] = nbits[7:0];
    for (t = 0; t < 16; t++)
      sched[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
    for (t = 16; t < 80; t++)
      sched[t] = rol32(sched[t - 3] ^ sched[t - 8] ^ sched[t - 14] ^ sched[t - 16], 1);
    a = iv_word(0);
    b = iv_word(1);
    c = iv_word(2);
    d = iv_word(3);
    e = iv_word(4);
    for (t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
      end else if (t >= 40 && t < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      tmp = rol32(a, 5) + f + e + sched[t] + mix_const(t);
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    for (t = 0; t < 5; t++) begin
      case (t)
        0:       item.word = a + iv_word(0);
        1:       item.word = b + iv_word(1);
        2:       item.word = c + iv_word(2);
        3:       item.word = d + iv_word(3);
        default: item.word = e + iv_word(4);
      endcase
      item.index   = t[2:0];
      item.final_w = (t == 4);
      item.status  = sha1sb_pkg::STATUS_OK;
      expected_words.push_back(item);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    digest_item_t item;
    if (buffered_bytes < sha1sb_pkg::BUF_BYTES) begin
      msg_bytes[buffered_bytes] = b;
      buffered_bytes++;
    end else begin
      overran = 1'b1;
    end
    if (is_last) begin
      if (overran) begin
        item.word    = 32'h0;
        item.index   = 3'd0;
        item.final_w = 1'b1;
        item.status  = sha1sb_pkg::STATUS_LONG;
        expected_words.push_back(item);
      end else begin
        predict_digest();
      end
      buffered_bytes = 0;
      overran = 1'b0;
    end
  endtask

  task automatic check_word();
    digest_item_t exp_item;
    if (expected_words.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result item: word=%h idx=%0d fin=%0b st=%0b",
                 out_digest_word, out_word_index, out_final_word, out_status);
      fail_count++;
    end else begin
      exp_item = expected_words.pop_front();
      words_checked++;
      if (exp_item.word !== out_digest_word || exp_item.index !== out_word_index ||
          exp_item.final_w !== out_final_word || exp_item.status !== out_status) begin
        if (fail_count < 10)
          $display({"digest mismatch: exp word=%h idx=%0d fin=%0b st=%0b,",
                    " got word=%h idx=%0d fin=%0b st=%0b"},
                   exp_item.word, exp_item.index, exp_item.final_w, exp_item.status,
                   out_digest_word, out_word_index, out_final_word, out_status);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count     = 0;
      pending_words  = 0;
      words_checked  = 0;
      buffered_bytes = 0;
      overran        = 1'b0;
    end else begin
      if (start && !busy) absorb_byte(in_data_byte, in_last_byte);
      if (out_strobe) check_word();
      pending_words = expected_words.size();
    end
  end

endmodule

@@ test/tb_sha1_single_block_hash.sv @@
// testbench top for sha1_single_block_hash: drives message bytes with random gaps,
// watches for stalls and prints the verdict
// depends on sha1_digest_checker and the rtl under hdl

module tb_sha1_single_block_hash;

  localparam int STALL_LIMIT  = 3000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 130;   // one full hash pass plus margin
  localparam int RANDOM_ITEMS = 140;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_strobe;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;
  logic        out_status;

  int fail_count;
  int pending_words;
  int words_checked;
  int stall_cycles;
  int bytes_sent;
  int messages_sent;
  int long_messages;
  int random_bytes;

  sha1_single_block_hash dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_strobe      (out_strobe),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word),
    .out_status      (out_status)
  );

  // the checker sees the same handshakes as the block and keeps the scoreboard
  sha1_digest_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_strobe      (out_strobe),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending_words   (pending_words),
    .words_checked   (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a stuck handshake or a lost result ends the run here
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d result items still due",
                 stall_cycles, pending_words);
        $display("** sha1_single_block_hash: FAILED **");
        $finish;
      end
    end
  end

  // idle length after an item: mostly none or short, now and then long enough
  // to cover the whole round phase of the engine
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(40, 160);
  endfunction

  // present one byte from the falling edge and hold it until busy is low at a
  // rising edge; start stays high if the next item follows with no gap
  task automatic send_byte(input logic [7:0] b, input logic is_last, input int gap);
    @(negedge clk);
    start        <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    bytes_sent++;
    if (is_last) messages_sent++;
    if (gap > 0) begin
      // junk on the data ports while start is low must be ignored
      @(negedge clk);
      start        <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // a message of len bytes with random content; back_to_back drops every gap
  task automatic send_random_message(input int len, input bit back_to_back);
    int i;
    if (len > 55) long_messages++;
    for (i = 0; i < len; i++)
      send_byte(8'($urandom), (i == len - 1), back_to_back ? 0 : idle_gap());
    random_bytes += len;
  endtask

  initial begin
    int len;
    int r;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    bytes_sent   = 0;
    messages_sent = 0;
    long_messages = 0;
    random_bytes = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: the classic three-byte message
    send_byte("a", 1'b0, 0);
    send_byte("b", 1'b0, 0);
    send_byte("c", 1'b1, 0);
    // single-byte messages at both byte extremes, back to back so busy rises
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'h80, 1'b1, 2);
    // alternating bit patterns and complementary byte pairs, then bytes near the pad value
    send_byte(8'h55, 1'b0, 0);
    send_byte(8'hAA, 1'b0, 1);
    send_byte(8'h55, 1'b0, 0);
    send_byte(8'hAA, 1'b0, 0);
    send_byte(8'h0F, 1'b0, 3);
    send_byte(8'hF0, 1'b0, 0);
    send_byte(8'h01, 1'b0, 0);
    send_byte(8'hFE, 1'b1, 0);
    send_byte(8'h7F, 1'b0, 0);
    send_byte(8'h80, 1'b0, 0);
    send_byte(8'h81, 1'b1, 5);

    // random: the longest message that still hashes and the shortest that
    // overflows come first, then a mix dominated by short messages
    send_random_message(55, 1'b0);
    send_random_message(56, 1'b1);
    while (random_bytes < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        len = $urandom_range(1, 8);
      end else if (r < 8) begin
        len = $urandom_range(9, 55);
      end else if (r == 8) begin
        len = 55;
      end else begin
        len = $urandom_range(56, 64);
      end
      send_random_message(len, ($urandom_range(0, 3) == 0));
    end

    @(negedge clk);
    start <= 1'b0;

    // drain: the watchdog catches results that never come
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d messages, %0d of them over 55 bytes",
             bytes_sent, messages_sent, long_messages);
    $display("checked %0d result items, %0d failures", words_checked, fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("** sha1_single_block_hash: PASSED **");
    end else begin
      $display("** sha1_single_block_hash: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sha1sb_pkg.sv
hdl/sha1sb_ram.sv
hdl/sha1sb_front.sv
hdl/sha1sb_queue.sv
hdl/sha1sb_back.sv
hdl/sha1_single_block_hash.sv
test/sha1_digest_checker.sv
test/tb_sha1_single_block_hash.sv
